// File: design/ps2_mouse_packet_cursor_assert.svh
// Assertion macros shared by the mouse packet decoder RTL.
// Plain text only; depends on nothing else in the project.
`ifndef PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ps2mpc_pkg.sv
// Shared types and constants for the mouse packet decoder.
// Used by ps2mpc_clamp and ps2_mouse_packet_cursor; no dependencies.
package ps2mpc_pkg;

   localparam int COORD_BITS  = 12;
   localparam int CURSOR_SIZE = 16;
   localparam int TASKBAR_H   = 28;
   localparam int DELTA_X_W   = 9;
   localparam int DELTA_Y_W   = 10;
   localparam int BUTTONS_W   = 3;
   localparam int CSR_INDEX_W = 2;

   localparam int RESET_WIDTH  = 320;
   localparam int RESET_HEIGHT = 200;

   localparam logic [COORD_BITS-1:0] RESET_SCREEN_W = COORD_BITS'(RESET_WIDTH);
   localparam logic [COORD_BITS-1:0] RESET_SCREEN_H = COORD_BITS'(RESET_HEIGHT);
   localparam logic [COORD_BITS-1:0] RESET_CURSOR_X =
      COORD_BITS'((RESET_WIDTH - CURSOR_SIZE) / 2);
   localparam logic [COORD_BITS-1:0] RESET_CURSOR_Y =
      COORD_BITS'((RESET_HEIGHT - TASKBAR_H - CURSOR_SIZE) / 2);

   localparam logic [7:0] ACK_BYTE = 8'hFA;
   localparam int HEAD_X_SIGN_BIT = 4;
   localparam int HEAD_Y_SIGN_BIT = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      PHASE_ACK  = 2'd0,
      PHASE_HEAD = 2'd1,
      PHASE_DX   = 2'd2,
      PHASE_DY   = 2'd3
   } phase_type;

endpackage

// File: design/ps2_mouse_packet_cursor.sv
// Top level of the mouse packet decoder and cursor tracker.
// Depends on ps2mpc_pkg, ps2mpc_clamp and ps2_mouse_packet_cursor_assert.svh.

// Accepts one mouse byte per clock. Bytes are dropped until the 0xFA
// acknowledge arrives; after that every third byte completes a packet and
// yields one response, registered and shown the cycle after that byte is
// accepted. The response carries the buttons, both movements and the new
// clamped cursor position. The rate is one byte per cycle, set by the single
// add-and-clamp stage per axis that sits before the response register. A
// third packet byte waits only while an earlier response is still untaken;
// other bytes are accepted regardless. Screen size registers must be written
// through the csr port while the block is idle, unenforced by the block; they
// apply at the next clamp. The cursor starts mid-screen above the taskbar.
module ps2_mouse_packet_cursor (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [7:0]                              req_mouse_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [ps2mpc_pkg::BUTTONS_W-1:0]        rsp_buttons,
   output logic signed [ps2mpc_pkg::DELTA_X_W-1:0] rsp_delta_x,
   output logic signed [ps2mpc_pkg::DELTA_Y_W-1:0] rsp_delta_y,
   output logic [ps2mpc_pkg::COORD_BITS-1:0]       rsp_cursor_x,
   output logic [ps2mpc_pkg::COORD_BITS-1:0]       rsp_cursor_y,
   input  logic                                    csr_we,
   input  logic [ps2mpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ps2mpc_pkg::COORD_BITS-1:0]       csr_wdata
);
   import ps2mpc_pkg::*;

   `include "ps2_mouse_packet_cursor_assert.svh"

   phase_type                    phase_ff, phase_in;
   logic [7:0]                   head_ff;
   logic [7:0]                   dx_byte_ff;
   logic [COORD_BITS-1:0]        width_ff, height_ff;
   logic [COORD_BITS-1:0]        cur_x_ff, cur_y_ff;
   logic [COORD_BITS-1:0]        cur_x_in, cur_y_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [BUTTONS_W-1:0]         buttons_ff;
   logic signed [DELTA_X_W-1:0]  delta_x_ff, delta_x_in;
   logic signed [DELTA_Y_W-1:0]  delta_y_ff, delta_y_in;
   logic signed [DELTA_Y_W-1:0]  delta_x_wide;
   logic signed [DELTA_X_W-1:0]  dy_raw;
   logic                         accept;
   logic                         fire;

   // Only a packet-completing byte needs room in the response register.
   assign req_ready = !rsp_valid_ff || rsp_ready || (phase_ff != PHASE_DY);
   assign accept    = req_valid && req_ready;

   // Next packet phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PHASE_ACK: begin
               if (req_mouse_byte == ACK_BYTE) begin
                  phase_in = PHASE_HEAD;
               end
            end
            PHASE_HEAD: phase_in = PHASE_DX;
            PHASE_DX:   phase_in = PHASE_DY;
            PHASE_DY:   phase_in = PHASE_HEAD;
            default:    phase_in = PHASE_ACK;
         endcase
      end
   end

   // Packet decode and response control.
   always_comb begin
      fire         = accept && (phase_ff == PHASE_DY);
      delta_x_in   = $signed({head_ff[HEAD_X_SIGN_BIT], dx_byte_ff});
      delta_x_wide = $signed({delta_x_in[DELTA_X_W-1], delta_x_in});
      dy_raw       = $signed({head_ff[HEAD_Y_SIGN_BIT], req_mouse_byte});
      delta_y_in   = -$signed({dy_raw[DELTA_X_W-1], dy_raw});
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   ps2mpc_clamp u_clamp_x (
      .pos     (cur_x_ff),
      .delta   (delta_x_wide),
      .size    (width_ff),
      .new_pos (cur_x_in)
   );

   ps2mpc_clamp u_clamp_y (
      .pos     (cur_y_ff),
      .delta   (delta_y_in),
      .size    (height_ff),
      .new_pos (cur_y_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_ACK;
         rsp_valid_ff <= 1'b0;
         width_ff     <= RESET_SCREEN_W;
         height_ff    <= RESET_SCREEN_H;
         cur_x_ff     <= RESET_CURSOR_X;
         cur_y_ff     <= RESET_CURSOR_Y;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_SCREEN_WIDTH:  width_ff  <= csr_wdata;
               REG_SCREEN_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (fire) begin
            cur_x_ff <= cur_x_in;
            cur_y_ff <= cur_y_in;
         end
      end
   end

   // Packet bytes and response payload need no reset.
   always_ff @(posedge clock) begin
      if (accept && (phase_ff == PHASE_HEAD)) begin
         head_ff <= req_mouse_byte;
      end
      if (accept && (phase_ff == PHASE_DX)) begin
         dx_byte_ff <= req_mouse_byte;
      end
      if (fire) begin
         buttons_ff <= head_ff[BUTTONS_W-1:0];
         delta_x_ff <= delta_x_in;
         delta_y_ff <= delta_y_in;
      end
   end

   // The cursor only moves when a response is loaded, so it doubles as payload.
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_buttons  = buttons_ff;
   assign rsp_delta_x  = delta_x_ff;
   assign rsp_delta_y  = delta_y_ff;
   assign rsp_cursor_x = cur_x_ff;
   assign rsp_cursor_y = cur_y_ff;

   `ASSERT_NEXT_CYCLE(a_ack_gate, clock, reset,
      accept && (phase_ff == PHASE_ACK) && (req_mouse_byte != ACK_BYTE),
      phase_ff == PHASE_ACK, "non-acknowledge byte left the wait phase")
   `ASSERT_NEXT_CYCLE(a_third_byte_fires, clock, reset,
      accept && (phase_ff == PHASE_DY),
      rsp_valid_ff && (phase_ff == PHASE_HEAD), "third packet byte gave no response")
   `ASSERT_SAME_CYCLE(a_rsp_after_ack, clock, reset,
      rsp_valid_ff, phase_ff != PHASE_ACK, "response present before acknowledge")

endmodule

// File: design/ps2mpc_clamp.sv
// Adds a signed movement to one cursor coordinate and clamps it to the screen.
// Depends on ps2mpc_pkg for the coordinate width and cursor size.
module ps2mpc_clamp (
   input  logic [ps2mpc_pkg::COORD_BITS-1:0]       pos,
   input  logic signed [ps2mpc_pkg::DELTA_Y_W-1:0] delta,
   input  logic [ps2mpc_pkg::COORD_BITS-1:0]       size,
   output logic [ps2mpc_pkg::COORD_BITS-1:0]       new_pos
);
   import ps2mpc_pkg::*;

   localparam int SUM_W = COORD_BITS + 2;
   localparam int HI_W  = COORD_BITS + 1;

   logic signed [SUM_W-1:0] sum;
   logic signed [HI_W-1:0]  hi_raw;
   logic signed [SUM_W-1:0] hi;

   always_comb begin
      sum = $signed({2'b00, pos}) +
            $signed({{(SUM_W-DELTA_Y_W){delta[DELTA_Y_W-1]}}, delta});
      hi_raw = $signed({1'b0, size}) - $signed(HI_W'(CURSOR_SIZE));
      // A screen smaller than the cursor pins the upper bound at zero.
      if (hi_raw < 0) begin
         hi = '0;
      end else begin
         hi = $signed({{(SUM_W-HI_W){1'b0}}, hi_raw});
      end
      if (sum < 0) begin
         new_pos = '0;
      end else if (sum > hi) begin
         new_pos = hi[COORD_BITS-1:0];
      end else begin
         new_pos = sum[COORD_BITS-1:0];
      end
   end

endmodule

// File: sim/ps2_mouse_packet_cursor_test.sv
// Self-checking bench for ps2_mouse_packet_cursor: directed byte table, then random packets
// under several screen sizes. Each report is checked against its table row or a local decoder model.
// Depends on ps2mpc_pkg and the design sources only.
module ps2_mouse_packet_cursor_test;
   import ps2mpc_pkg::*;

   typedef struct packed {
      logic [BUTTONS_W-1:0]        buttons;
      logic signed [DELTA_X_W-1:0] dx;
      logic signed [DELTA_Y_W-1:0] dy;
      logic [COORD_BITS-1:0]       cx;
      logic [COORD_BITS-1:0]       cy;
   } mouse_report_type;

   typedef struct packed {
      logic [7:0]       b;
      logic             typed;
      mouse_report_type want;
   } byte_row_type;

   // Indexes that decode to no register.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

   localparam int NUM_ROWS = 28;
   localparam byte_row_type BYTE_TABLE [0:NUM_ROWS-1] = '{
      '{8'h00, 1'b0, '0},  // bytes before the acknowledge are dropped
      '{8'hFF, 1'b0, '0},
      '{8'hF9, 1'b0, '0},
      '{8'hFA, 1'b0, '0},  // acknowledge
      '{8'h08, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, '{3'd0, 9'd0, 10'd0, 12'd152, 12'd78}},
      '{8'h07, 1'b0, '0},
      '{8'h05, 1'b0, '0},
      '{8'h03, 1'b0, '0},
      '{8'h30, 1'b0, '0},  // both sign bits with zero bytes: largest moves
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, '{3'd0, 9'(-256), 10'(256), 12'd0, 12'd184}},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b1, '{3'd0, 9'(255), 10'(-255), 12'd255, 12'd0}},
      '{8'hFA, 1'b0, '0},  // the acknowledge value inside a packet is data
      '{8'hFA, 1'b0, '0},
      '{8'hFA, 1'b0, '0},
      '{8'h17, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'h2D, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b1, '{3'd1, 9'(255), 10'(-255), 12'd304, 12'd0}}
   };

   // Screen sizes used by the random phases; the first is the reset size.
   localparam int NUM_SETTINGS = 9;
   localparam logic [COORD_BITS-1:0] SET_W [0:NUM_SETTINGS-1] =
      '{12'd320, 12'd16, 12'd4095, 12'd0, 12'd15, 12'd17, 12'd640, 12'd4095, 12'd320};
   localparam logic [COORD_BITS-1:0] SET_H [0:NUM_SETTINGS-1] =
      '{12'd200, 12'd44, 12'd4095, 12'd0, 12'd16, 12'd4095, 12'd480, 12'd44, 12'd200};

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [7:0]                  req_mouse_byte;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [BUTTONS_W-1:0]        rsp_buttons;
   logic signed [DELTA_X_W-1:0] rsp_delta_x;
   logic signed [DELTA_Y_W-1:0] rsp_delta_y;
   logic [COORD_BITS-1:0]       rsp_cursor_x;
   logic [COORD_BITS-1:0]       rsp_cursor_y;
   logic                        csr_we;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [COORD_BITS-1:0]       csr_wdata;

   ps2_mouse_packet_cursor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mouse_byte (req_mouse_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_buttons    (rsp_buttons),
      .rsp_delta_x    (rsp_delta_x),
      .rsp_delta_y    (rsp_delta_y),
      .rsp_cursor_x   (rsp_cursor_x),
      .rsp_cursor_y   (rsp_cursor_y),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Decoder model state.
   phase_type             dec_phase;
   logic [7:0]            head_byte;
   logic [7:0]            dx_byte;
   logic [COORD_BITS-1:0] cur_x;
   logic [COORD_BITS-1:0] cur_y;
   logic [COORD_BITS-1:0] scr_w;
   logic [COORD_BITS-1:0] scr_h;

   mouse_report_type expected_reports[$];
   mouse_report_type got_report;
   mouse_report_type want_report;
   int               errors = 0;
   int               bytes_sent = 0;
   int               reports_seen = 0;
   bit               sender_calm = 0;
   bit               receiver_calm = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Timed out with %0d reports outstanding.", expected_reports.size());
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Add a movement to one axis, clamp low to zero, then high to the screen
   // size less the cursor, which itself saturates at zero.
   function automatic logic [COORD_BITS-1:0] clamp_axis(input logic [COORD_BITS-1:0] pos,
                                                        input int delta,
                                                        input logic [COORD_BITS-1:0] size);
      int p;
      int hi;
      p = int'(pos) + delta;
      hi = int'(size) - CURSOR_SIZE;
      if (p < 0) p = 0;
      if (hi < 0) hi = 0;
      if (p > hi) p = hi;
      return COORD_BITS'(p);
   endfunction

   function automatic bit predict_report(input logic [7:0] b, output mouse_report_type r);
      int dx;
      int dy;
      r = '0;
      case (dec_phase)
         PHASE_ACK: begin
            if (b == ACK_BYTE) dec_phase = PHASE_HEAD;
            return 1'b0;
         end
         PHASE_HEAD: begin
            head_byte = b;
            dec_phase = PHASE_DX;
            return 1'b0;
         end
         PHASE_DX: begin
            dx_byte = b;
            dec_phase = PHASE_DY;
            return 1'b0;
         end
         default: begin
         end
      endcase
      dec_phase = PHASE_HEAD;
      dx = int'(dx_byte);
      if (head_byte[HEAD_X_SIGN_BIT]) dx -= 256;
      dy = int'(b);
      if (head_byte[HEAD_Y_SIGN_BIT]) dy -= 256;
      dy = -dy;
      cur_x = clamp_axis(cur_x, dx, scr_w);
      cur_y = clamp_axis(cur_y, dy, scr_h);
      r.buttons = head_byte[BUTTONS_W-1:0];
      r.dx = DELTA_X_W'(dx);
      r.dy = DELTA_Y_W'(dy);
      r.cx = cur_x;
      r.cy = cur_y;
      return 1'b1;
   endfunction

   // Called and returns at a falling edge; valid stays high between
   // back-to-back requests.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input mouse_report_type typed_want);
      int               gap;
      mouse_report_type model_out;
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mouse_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (predict_report(b, model_out))
         expected_reports.push_back(typed ? typed_want : model_out);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_packet();
      logic [7:0] head;
      logic [7:0] dxb;
      logic [7:0] dyb;
      int         mag;
      head = 8'($urandom);
      if ($urandom_range(0, 1) == 1) begin
         // Small moves whose byte agrees with the header sign bit.
         mag = $urandom_range(0, 12);
         dxb = head[HEAD_X_SIGN_BIT] ? ~8'(mag) : 8'(mag);
         mag = $urandom_range(0, 12);
         dyb = head[HEAD_Y_SIGN_BIT] ? ~8'(mag) : 8'(mag);
      end else begin
         dxb = 8'($urandom);
         dyb = 8'($urandom);
      end
      send_byte(head, 1'b0, '0);
      send_byte(dxb, 1'b0, '0);
      send_byte(dyb, 1'b0, '0);
   endtask

   // Stop sending and wait until every report is in, then wait on for any
   // bytes that produce no report.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [COORD_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == REG_SCREEN_WIDTH) scr_w = data;
      else if (idx == REG_SCREEN_HEIGHT) scr_h = data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Response sink with random back-pressure.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) receiver_calm = !receiver_calm;
         gap = receiver_calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_report = '{rsp_buttons, rsp_delta_x, rsp_delta_y, rsp_cursor_x, rsp_cursor_y};
         reports_seen++;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected report %p", got_report));
         end else begin
            want_report = expected_reports.pop_front();
            if (got_report.buttons !== want_report.buttons)
               report_mismatch($sformatf("buttons %0d, expected %0d",
                                         got_report.buttons, want_report.buttons));
            if (got_report.dx !== want_report.dx)
               report_mismatch($sformatf("delta_x %0d, expected %0d",
                                         got_report.dx, want_report.dx));
            if (got_report.dy !== want_report.dy)
               report_mismatch($sformatf("delta_y %0d, expected %0d",
                                         got_report.dy, want_report.dy));
            if (got_report.cx !== want_report.cx)
               report_mismatch($sformatf("cursor_x %0d, expected %0d",
                                         got_report.cx, want_report.cx));
            if (got_report.cy !== want_report.cy)
               report_mismatch($sformatf("cursor_y %0d, expected %0d",
                                         got_report.cy, want_report.cy));
         end
      end
   end

   initial begin
      int budget;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mouse_byte = 8'h00;
      csr_we = 1'b0;
      csr_index = REG_SCREEN_WIDTH;
      csr_wdata = '0;
      dec_phase = PHASE_ACK;
      head_byte = 8'h00;
      dx_byte = 8'h00;
      scr_w = RESET_SCREEN_W;
      scr_h = RESET_SCREEN_H;
      cur_x = RESET_CURSOR_X;
      cur_y = RESET_CURSOR_Y;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_ROWS; i++)
         send_byte(BYTE_TABLE[i].b, BYTE_TABLE[i].typed, BYTE_TABLE[i].want);

      for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
         if (ph > 0) begin
            settle();
            write_csr(REG_SCREEN_WIDTH, SET_W[ph]);
            write_csr(REG_SCREEN_HEIGHT, SET_H[ph]);
            write_csr((ph % 2 == 1) ? REG_UNUSED_2 : REG_UNUSED_3, COORD_BITS'($urandom));
         end
         budget = $urandom_range(190, 230);
         while (budget > 0) begin
            if ($urandom_range(0, 15) == 0) begin
               // A lone byte shifts the packet framing; the block does not resync.
               send_byte(8'($urandom), 1'b0, '0);
               budget -= 1;
            end else begin
               send_packet();
               budget -= 3;
            end
            if ($urandom_range(0, 79) == 0) settle();
         end
      end

      req_valid <= 1'b0;
      for (int k = 0; k < 5000 && expected_reports.size() != 0; k++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (expected_reports.size() != 0)
         report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));

      $display("Sent %0d mouse bytes and checked %0d cursor reports across %0d screen sizes.",
               bytes_sent, reports_seen, NUM_SETTINGS);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches.", errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/ps2mpc_pkg.sv
design/ps2mpc_clamp.sv
design/ps2_mouse_packet_cursor.sv
sim/ps2_mouse_packet_cursor_test.sv
